@@ rtl/core/mcts_ucs_pkg.sv @@
package mcts_ucs_pkg;

  localparam int MAX_CHILDREN = 64;
  localparam int IDX_W        = $clog2(MAX_CHILDREN);
  localparam int CNT_W        = IDX_W + 1;
  localparam int VISIT_BITS   = 24;
  localparam int GIDX_W       = 24;
  localparam int SUM_W        = 32;
  localparam int LN_W         = 21;
  localparam int PRIO_W       = 50;
  localparam int DIVN_W       = 48;
  localparam int DIVD_W       = 32;
  localparam int SQ_W         = 38;
  localparam int CFG_W        = 24;

  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [VISIT_BITS-1:0] VISIT_MAX = '1;

  // command codes
  localparam logic [2:0] CMD_UPDATE = 3'd0;
  localparam logic [2:0] CMD_SELECT = 3'd1;
  localparam logic [2:0] CMD_EXPAND = 3'd2;
  localparam logic [2:0] CMD_BEST   = 3'd3;
  localparam logic [2:0] CMD_FIND   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_TERM = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CHILD_COUNT = 2'd0;
  localparam logic [1:0] REG_FIRST_CHILD = 2'd1;
  localparam logic [1:0] REG_MAX_SCORE   = 2'd2;
  localparam logic [1:0] REG_EXPLORE     = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_UPD_RD, S_UPD_WR,
    S_LOG_MUL, S_LOG_STEP, S_LOG_SCALE, S_LOG_DONE,
    S_SEL_RD, S_SEL_CHK, S_SEL_MEAN, S_SEL_Q, S_SEL_ROOT, S_SQRT, S_SEL_EXP,
    S_SEL_ACC, S_SEL_MOD, S_SEL_P2_INIT, S_SEL_P2_RD, S_SEL_P2_CHK,
    S_DIV,
    S_EXP_MOD, S_EXP_RD_E, S_EXP_RD_J, S_EXP_WR1, S_EXP_WR2,
    S_BEST_RD, S_BEST_CMP,
    S_FIND_RD, S_FIND_CMP,
    S_SLOT_RD, S_SLOT_WAIT,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/mcts_uct_child_selector_unit.sv @@
// uct child selection for one monte carlo tree search node
// channels: request in (in_valid/in_ready) carrying command, child_id,
//   score, random_value and move_id; result out (out_valid/out_ready), one
//   result per request; config via cfg_we/cfg_index/cfg_data, one write a cycle
// in_ready is high only while the sequencer is idle, one request at a time
// work: update reads then writes the child when it is open, find and best
//   walk the children, expand runs one 48-step divide, select computes ln N,
//   then for each visited child runs two 48-step divides in the shared divider
//   and a 19-step square root, then one 48-step divide for the tie pick and
//   the tie walk; the divider is a shared 48-step restoring divider and the
//   multiplier a shared 32x32 multiplier; memories are read one address per
//   cycle
// reset: node empty, child count 0, first child 1, max score 100,
//   exploration weight 5793, move slots read as the identity permutation
// a stalled receiver holds the result in the output register; the next
//   request is taken while it waits, and its result waits in S_DONE
module mcts_uct_child_selector_unit
  import mcts_ucs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            command,
  input  logic [GIDX_W-1:0]     child_id,
  input  logic [7:0]            score,
  input  logic [31:0]           random_value,
  input  logic [5:0]            move_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [GIDX_W-1:0]     chosen_child_index,
  output logic [5:0]            chosen_move,
  output logic                  leaf_node,
  output logic                  fully_expanded,
  output logic [1:0]            status,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  // configuration
  logic [6:0]              child_count;
  logic [GIDX_W-1:0]       first_child_index;
  logic [7:0]              max_expected_score;
  logic [15:0]             exploration_weight;

  // node state
  logic [VISIT_BITS-1:0]   node_visits;
  logic [CNT_W-1:0]        expanded_count;

  // child stores, visit and sum entries are zeroed when expanded
  logic [VISIT_BITS-1:0]   vis_mem  [MAX_CHILDREN];
  logic [SUM_W-1:0]        sum_mem  [MAX_CHILDREN];
  logic [5:0]              slot_mem [MAX_CHILDREN];
  logic [PRIO_W-1:0]       prio_mem [MAX_CHILDREN];
  logic [MAX_CHILDREN-1:0] slot_valid;

  logic [VISIT_BITS-1:0]   vis_q;
  logic [SUM_W-1:0]        sum_q;
  logic [5:0]              slot_q;
  logic                    slot_vq;
  logic [IDX_W-1:0]        addr_q;
  logic [PRIO_W-1:0]       prio_q;
  logic [5:0]              slot_val;

  state_t state, state_next;

  // request
  logic [7:0]              score_r;
  logic [31:0]             rnd;
  logic [5:0]              move_r;

  // walk
  logic [CNT_W-1:0]        idx;
  logic [IDX_W-1:0]        pick;
  logic                    have;
  logic [1:0]              stat;
  logic [5:0]              cmove;
  logic [VISIT_BITS-1:0]   best_vis;
  logic [IDX_W-1:0]        jdx;
  logic [5:0]              tmp_e;

  // log
  logic [4:0]              lk;
  logic [31:0]             lm;
  logic [15:0]             frac;
  logic [3:0]              lit;
  logic [LN_W-1:0]         ln_n;

  // select
  logic [VISIT_BITS-1:0]   n_r;
  logic [SUM_W-1:0]        s_r;
  logic                    unv;
  logic [DIVN_W-1:0]       mean_r;
  logic [PRIO_W-1:0]       best_p;
  logic [CNT_W-1:0]        ties;
  logic [CNT_W-1:0]        kk;
  logic [PRIO_W-1:0]       prio;

  // shared multiplier
  logic [31:0]             mul_a, mul_b;
  logic [63:0]             prod;

  // shared divider
  logic [DIVN_W-1:0]       div_n;
  logic [DIVD_W:0]         div_r;
  logic [DIVD_W-1:0]       div_d;
  logic [5:0]              div_cnt;
  state_t                  div_ret;
  logic [DIVD_W:0]         div_rr;
  logic                    div_ge;

  // square root
  logic [SQ_W-1:0]         sq_v, sq_r, sq_b;
  logic [SQ_W-1:0]         sq_rb;

  // misc combinational
  logic [CNT_W-1:0]        cnt;
  logic [7:0]              divisor;
  logic [GIDX_W-1:0]       off;
  logic                    off_hit;
  logic [IDX_W-1:0]        rd_addr;
  logic                    accept;
  logic                    load_out;
  logic [1:0]              acc_status;
  logic [4:0]              nv_msb;
  logic [SUM_W:0]          sum_add;
  logic [SQ_W-1:0]         sq_init;

  assign cnt      = (child_count > 7'(MAX_CHILDREN)) ? CNT_W'(MAX_CHILDREN)
                                                      : CNT_W'(child_count);
  assign divisor  = (max_expected_score == 8'd0) ? 8'd1 : max_expected_score;
  assign off      = child_id - first_child_index;
  assign off_hit  = off < GIDX_W'(expanded_count);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);
  assign slot_val = slot_vq ? slot_q : 6'(addr_q);
  assign sum_add  = {1'b0, sum_q} + (SUM_W+1)'(score_r);
  assign div_rr   = {div_r[DIVD_W-1:0], div_n[DIVN_W-1]};
  assign div_ge   = div_rr >= {1'b0, div_d};
  assign sq_rb    = sq_r + sq_b;
  assign sq_init  = SQ_W'(1) << (SQ_W - 2);
  assign prio     = unv ? '1 : (PRIO_W'(mean_r) + PRIO_W'(prod[34:12]));

  // msb of node visit count
  always_comb begin
    nv_msb = '0;
    for (int b = 0; b < VISIT_BITS; b++) begin
      if (node_visits[b]) nv_msb = 5'(b);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    acc_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DONE;
          if (command == CMD_UPDATE) begin
            if (child_id != '0) begin
              if (off_hit) state_next = S_UPD_RD;
              else acc_status = ST_MISS;
            end
          end else if (command > CMD_FIND) begin
            acc_status = ST_MISS;
          end else if (cnt == '0) begin
            acc_status = ST_TERM;
          end else if (command == CMD_SELECT) begin
            if (expanded_count < cnt) acc_status = ST_MISS;
            else if (node_visits < VISIT_BITS'(2)) state_next = S_SEL_RD;
            else state_next = S_LOG_MUL;
          end else if (command == CMD_EXPAND) begin
            if (expanded_count >= cnt) acc_status = ST_MISS;
            else state_next = S_EXP_MOD;
          end else if (command == CMD_BEST) begin
            if (expanded_count == '0) acc_status = ST_MISS;
            else state_next = S_BEST_RD;
          end else begin
            state_next = S_FIND_RD;
          end
        end
      end
      S_UPD_RD:      state_next = S_UPD_WR;
      S_UPD_WR:      state_next = S_DONE;
      S_LOG_MUL:     state_next = S_LOG_STEP;
      S_LOG_STEP:    state_next = (lit == 4'd15) ? S_LOG_SCALE : S_LOG_MUL;
      S_LOG_SCALE:   state_next = S_LOG_DONE;
      S_LOG_DONE:    state_next = S_SEL_RD;
      S_SEL_RD:      state_next = S_SEL_CHK;
      S_SEL_CHK:     state_next = (vis_q == '0) ? S_SEL_ACC : S_SEL_MEAN;
      S_SEL_MEAN:    state_next = S_DIV;
      S_SEL_Q:       state_next = S_DIV;
      S_SEL_ROOT:    state_next = S_SQRT;
      S_SQRT:        state_next = (sq_b == SQ_W'(1)) ? S_SEL_EXP : S_SQRT;
      S_SEL_EXP:     state_next = S_SEL_ACC;
      S_SEL_ACC:     state_next = (idx + CNT_W'(1) == cnt) ? S_SEL_MOD : S_SEL_RD;
      S_SEL_MOD:     state_next = S_DIV;
      S_SEL_P2_INIT: state_next = S_SEL_P2_RD;
      S_SEL_P2_RD:   state_next = S_SEL_P2_CHK;
      S_SEL_P2_CHK: begin
        if (prio_q == best_p && kk == '0) state_next = S_SLOT_RD;
        else state_next = S_SEL_P2_RD;
      end
      S_DIV:         state_next = (div_cnt == 6'(DIVN_W - 1)) ? div_ret : S_DIV;
      S_EXP_MOD:     state_next = S_DIV;
      S_EXP_RD_E:    state_next = S_EXP_RD_J;
      S_EXP_RD_J:    state_next = S_EXP_WR1;
      S_EXP_WR1:     state_next = S_EXP_WR2;
      S_EXP_WR2:     state_next = S_DONE;
      S_BEST_RD:     state_next = S_BEST_CMP;
      S_BEST_CMP: begin
        state_next = (idx + CNT_W'(1) == expanded_count) ? S_SLOT_RD : S_BEST_RD;
      end
      S_FIND_RD:     state_next = S_FIND_CMP;
      S_FIND_CMP: begin
        if (slot_val == move_r) state_next = S_DONE;
        else if (idx + CNT_W'(1) == cnt) state_next = S_DONE;
        else state_next = S_FIND_RD;
      end
      S_SLOT_RD:     state_next = S_SLOT_WAIT;
      S_SLOT_WAIT:   state_next = S_DONE;
      S_DONE:        state_next = load_out ? S_IDLE : S_DONE;
      default:       state_next = S_IDLE;
    endcase
  end

  // memory address and multiplier operands
  always_comb begin
    rd_addr = idx[IDX_W-1:0];
    mul_a   = '0;
    mul_b   = '0;
    case (state)
      S_SLOT_RD:  rd_addr = pick;
      S_EXP_RD_E: rd_addr = expanded_count[IDX_W-1:0];
      S_EXP_RD_J: rd_addr = jdx;
      S_LOG_MUL: begin
        mul_a = lm;
        mul_b = lm;
      end
      S_LOG_SCALE: begin
        mul_a = 32'({lk, frac});
        mul_b = 32'(LN2_Q16);
      end
      S_SEL_CHK: begin
        mul_a = 32'(divisor);
        mul_b = 32'(vis_q);
      end
      S_SEL_EXP: begin
        mul_a = 32'(exploration_weight);
        mul_b = sq_r[31:0];
      end
      default: begin
        rd_addr = idx[IDX_W-1:0];
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    vis_q   <= vis_mem[rd_addr];
    sum_q   <= sum_mem[rd_addr];
    slot_q  <= slot_mem[rd_addr];
    slot_vq <= slot_valid[rd_addr];
    addr_q  <= rd_addr;
    prio_q  <= prio_mem[rd_addr];
    prod    <= mul_a * mul_b;
    if (state == S_UPD_WR) begin
      vis_mem[idx[IDX_W-1:0]] <= (vis_q == VISIT_MAX) ? vis_q : vis_q + VISIT_BITS'(1);
      sum_mem[idx[IDX_W-1:0]] <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end
    if (state == S_EXP_WR1) begin
      vis_mem[expanded_count[IDX_W-1:0]]  <= '0;
      sum_mem[expanded_count[IDX_W-1:0]]  <= '0;
      slot_mem[expanded_count[IDX_W-1:0]] <= slot_val;
    end
    if (state == S_EXP_WR2) begin
      slot_mem[jdx] <= tmp_e;
    end
    if (state == S_SEL_ACC) begin
      prio_mem[idx[IDX_W-1:0]] <= prio;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      child_count        <= '0;
      first_child_index  <= GIDX_W'(1);
      max_expected_score <= 8'd100;
      exploration_weight <= 16'd5793;
      node_visits        <= '0;
      expanded_count     <= '0;
      slot_valid         <= '0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_CHILD_COUNT: begin
            child_count    <= cfg_data[6:0];
            node_visits    <= '0;
            expanded_count <= '0;
            slot_valid     <= '0;
          end
          REG_FIRST_CHILD: first_child_index  <= cfg_data[GIDX_W-1:0];
          REG_MAX_SCORE:   max_expected_score <= cfg_data[7:0];
          REG_EXPLORE:     exploration_weight <= cfg_data[15:0];
          default:         child_count        <= child_count;
        endcase
      end
      if (accept && command == CMD_UPDATE && node_visits != VISIT_MAX) begin
        node_visits <= node_visits + VISIT_BITS'(1);
      end
      if (state == S_EXP_WR1) begin
        slot_valid[expanded_count[IDX_W-1:0]] <= 1'b1;
      end
      if (state == S_EXP_WR2) begin
        slot_valid[jdx] <= 1'b1;
        expanded_count  <= expanded_count + CNT_W'(1);
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        score_r <= score;
        rnd     <= random_value;
        move_r  <= move_id;
        stat    <= acc_status;
        have    <= 1'b0;
        pick    <= '0;
        idx     <= (command == CMD_UPDATE) ? CNT_W'(off[IDX_W-1:0]) : '0;
        ln_n    <= '0;
        lk      <= nv_msb;
        lm      <= 32'({8'd0, node_visits} << (5'd30 - nv_msb));
        frac    <= '0;
        lit     <= '0;
        best_p  <= '0;
        ties    <= '0;
      end
      S_LOG_STEP: begin
        lit <= lit + 4'd1;
        if (prod[61]) begin
          lm   <= {1'b0, prod[61:31]};
          frac <= {frac[14:0], 1'b1};
        end else begin
          lm   <= prod[61:30];
          frac <= {frac[14:0], 1'b0};
        end
      end
      S_LOG_DONE: ln_n <= prod[LN_W+15:16];
      S_SEL_CHK: begin
        unv <= (vis_q == '0);
        n_r <= vis_q;
        s_r <= sum_q;
      end
      S_SEL_MEAN: begin
        div_n   <= {s_r, 16'd0};
        div_d   <= prod[DIVD_W-1:0];
        div_r   <= '0;
        div_cnt <= '0;
        div_ret <= S_SEL_Q;
      end
      S_SEL_Q: begin
        mean_r  <= div_n;
        div_n   <= DIVN_W'(ln_n);
        div_d   <= DIVD_W'(n_r);
        div_r   <= '0;
        div_cnt <= '0;
        div_ret <= S_SEL_ROOT;
      end
      S_SEL_ROOT: begin
        sq_v <= SQ_W'({div_n[LN_W-1:0], 16'd0});
        sq_r <= '0;
        sq_b <= sq_init;
      end
      S_SQRT: begin
        if (sq_v >= sq_rb) begin
          sq_v <= sq_v - sq_rb;
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_b <= sq_b >> 2;
      end
      S_SEL_ACC: begin
        idx <= idx + CNT_W'(1);
        if (idx == '0 || prio > best_p) begin
          best_p <= prio;
          ties   <= CNT_W'(1);
        end else if (prio == best_p) begin
          ties <= ties + CNT_W'(1);
        end
      end
      S_SEL_MOD: begin
        div_n   <= DIVN_W'(rnd);
        div_d   <= DIVD_W'(ties);
        div_r   <= '0;
        div_cnt <= '0;
        div_ret <= S_SEL_P2_INIT;
      end
      S_SEL_P2_INIT: begin
        kk  <= div_r[CNT_W-1:0];
        idx <= '0;
      end
      S_SEL_P2_CHK: begin
        idx <= idx + CNT_W'(1);
        if (prio_q == best_p) begin
          if (kk == '0) begin
            pick <= idx[IDX_W-1:0];
            have <= 1'b1;
          end else begin
            kk <= kk - CNT_W'(1);
          end
        end
      end
      S_DIV: begin
        div_cnt <= div_cnt + 6'd1;
        div_r   <= div_ge ? (div_rr - {1'b0, div_d}) : div_rr;
        div_n   <= {div_n[DIVN_W-2:0], div_ge};
      end
      S_EXP_MOD: begin
        div_n   <= DIVN_W'(rnd);
        div_d   <= DIVD_W'(cnt - expanded_count);
        div_r   <= '0;
        div_cnt <= '0;
        div_ret <= S_EXP_RD_E;
      end
      S_EXP_RD_E: jdx <= IDX_W'(expanded_count + div_r[CNT_W-1:0]);
      S_EXP_RD_J: tmp_e <= slot_val;
      S_EXP_WR1: begin
        cmove <= slot_val;
        pick  <= expanded_count[IDX_W-1:0];
        have  <= 1'b1;
      end
      S_BEST_CMP: begin
        idx  <= idx + CNT_W'(1);
        have <= 1'b1;
        if (idx == '0 || vis_q > best_vis) begin
          best_vis <= vis_q;
          pick     <= idx[IDX_W-1:0];
        end
      end
      S_FIND_CMP: begin
        idx <= idx + CNT_W'(1);
        if (slot_val == move_r) begin
          pick  <= idx[IDX_W-1:0];
          cmove <= move_r;
          have  <= 1'b1;
        end else if (idx + CNT_W'(1) == cnt) begin
          stat <= ST_MISS;
        end
      end
      S_SLOT_WAIT: cmove <= slot_val;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      chosen_child_index <= have ? (first_child_index + GIDX_W'(pick)) : '0;
      chosen_move        <= have ? cmove : '0;
      leaf_node          <= (cnt == '0);
      fully_expanded     <= (expanded_count == cnt);
      status             <= stat;
    end
  end

endmodule

@@ rtl/core/mcts_ucs_checker.sv @@
module mcts_ucs_checker
  import mcts_ucs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [GIDX_W-1:0] chosen_child_index,
  input logic [5:0]        chosen_move,
  input logic              leaf_node,
  input logic              fully_expanded,
  input logic [1:0]        status
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chosen_child_index)
      && $stable(status) && $stable(chosen_move))
    else $error("result changed while stalled");

  // failed requests carry no child
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> chosen_child_index == '0 && chosen_move == '0)
    else $error("child given with error status");

  // a node without children is trivially fully expanded
  a_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && leaf_node |-> fully_expanded)
    else $error("terminal node not fully expanded");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind mcts_uct_child_selector_unit mcts_ucs_checker u_mcts_ucs_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import mcts_ucs_pkg::*;

  typedef longint unsigned u64;

  // one request as driven on the input channel
  typedef struct {
    logic [2:0]        cmd;
    logic [GIDX_W-1:0] cidx;
    logic [7:0]        scr;
    logic [31:0]       rnd;
    logic [5:0]        mv;
  } node_req_t;

  // one result as seen on the output channel
  typedef struct {
    logic [GIDX_W-1:0] gidx;
    logic [5:0]        mv;
    logic              term;
    logic              full;
    logic [1:0]        st;
  } node_res_t;

  // tracks the node statistics and holds the results still owed by the block
  class node_scoreboard;
    u64 kid_cfg, first_idx, score_div, c_weight;
    u64 node_n, open_cnt;
    u64 kid_n[MAX_CHILDREN];
    u64 kid_sum[MAX_CHILDREN];
    u64 slot[MAX_CHILDREN];
    node_res_t owed_q[$];
    int errors;

    function void clear_node();
      node_n = 0;
      open_cnt = 0;
      for (int i = 0; i < MAX_CHILDREN; i++) begin
        kid_n[i] = 0;
        kid_sum[i] = 0;
        slot[i] = i;
      end
    endfunction

    function void power_up();
      kid_cfg = 0;
      first_idx = 1;
      score_div = 100;
      c_weight = 5793;
      errors = 0;
      clear_node();
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_CHILD_COUNT: begin
          kid_cfg = val[6:0];
          clear_node();
        end
        REG_FIRST_CHILD: first_idx = val[23:0];
        REG_MAX_SCORE:   score_div = val[7:0];
        REG_EXPLORE:     c_weight = val[15:0];
        default: ;
      endcase
    endfunction

    function u64 isqrt(u64 v);
      u64 r, b;
      r = 0;
      b = u64'(1) << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // natural log in q16.16 through a squaring log2
    function u64 ln_fix(u64 n);
      u64 k, m, frac;
      k = 0;
      frac = 0;
      if (n < 2) return 0;
      while (k < 63 && (n >> (k + 1)) != 0) k++;
      m = (k <= 30) ? (n << (30 - k)) : (n >> (k - 30));
      for (int it = 0; it < 16; it++) begin
        m = (m * m) >> 30;
        frac <<= 1;
        if (m >= (u64'(1) << 31)) begin
          m >>= 1;
          frac |= 1;
        end
      end
      return (((k << 16) | frac) * 45426) >> 16;
    endfunction

    function u64 uct_value(int i, u64 ln_n);
      u64 n, dv, mean, rt;
      n = kid_n[i];
      dv = (score_div != 0) ? score_div : 1;
      if (n == 0) return '1;
      mean = (kid_sum[i] << 16) / (dv * n);
      rt = isqrt((ln_n / n) << 16);
      return mean + ((c_weight * rt) >> 12);
    endfunction

    function void note(node_req_t r);
      u64 cnt, pick, st, ln_n, top, ties, k, off, j, t, p;
      bit have;
      node_res_t e;
      cnt = (kid_cfg < MAX_CHILDREN) ? kid_cfg : MAX_CHILDREN;
      pick = 0;
      st = ST_OK;
      have = 0;
      top = 0;
      ties = 0;
      if (open_cnt > cnt) open_cnt = cnt;
      if (r.cmd == CMD_UPDATE) begin
        if (node_n < VISIT_MAX) node_n++;
        if (r.cidx != 0) begin
          off = (r.cidx - first_idx) & 24'hFFFFFF;
          if (off < open_cnt) begin
            if (kid_n[off] < VISIT_MAX) kid_n[off]++;
            kid_sum[off] += r.scr;
            if (kid_sum[off] > 64'hFFFF_FFFF) kid_sum[off] = 64'hFFFF_FFFF;
          end else begin
            st = ST_MISS;
          end
        end
      end else if (r.cmd > CMD_FIND) begin
        st = ST_MISS;
      end else if (cnt == 0) begin
        st = ST_TERM;
      end else if (r.cmd == CMD_SELECT) begin
        if (open_cnt < cnt) begin
          st = ST_MISS;
        end else begin
          ln_n = ln_fix(node_n);
          for (int i = 0; i < cnt; i++) begin
            p = uct_value(i, ln_n);
            if (i == 0 || p > top) begin
              top = p;
              ties = 1;
            end else if (p == top) begin
              ties++;
            end
          end
          k = r.rnd % ties;
          for (int i = 0; i < cnt; i++) begin
            if (uct_value(i, ln_n) == top) begin
              if (k == 0) begin
                pick = i;
                break;
              end
              k--;
            end
          end
          have = 1;
        end
      end else if (r.cmd == CMD_EXPAND) begin
        if (open_cnt >= cnt) begin
          st = ST_MISS;
        end else begin
          j = open_cnt + r.rnd % (cnt - open_cnt);
          t = slot[open_cnt];
          slot[open_cnt] = slot[j];
          slot[j] = t;
          kid_n[open_cnt] = 0;
          kid_sum[open_cnt] = 0;
          pick = open_cnt;
          open_cnt++;
          have = 1;
        end
      end else if (r.cmd == CMD_BEST) begin
        if (open_cnt == 0) begin
          st = ST_MISS;
        end else begin
          for (int i = 1; i < open_cnt; i++)
            if (kid_n[i] > kid_n[pick]) pick = i;
          have = 1;
        end
      end else begin
        for (int i = 0; i < cnt; i++) begin
          if (slot[i][5:0] == r.mv) begin
            pick = i;
            have = 1;
            break;
          end
        end
        if (!have) st = ST_MISS;
      end
      e.gidx = have ? GIDX_W'(first_idx + pick) : '0;
      e.mv   = have ? slot[pick][5:0] : '0;
      e.term = (cnt == 0);
      e.full = (open_cnt == cnt);
      e.st   = st[1:0];
      owed_q = {owed_q, e};
    endfunction

    task report(string what, u64 got, u64 want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check(node_res_t got);
      node_res_t e;
      if (owed_q.size() == 0) begin
        report("unexpected result, index", got.gidx, 0);
      end else begin
        e = owed_q.pop_front();
        if (got.gidx != e.gidx) report("chosen_child_index", got.gidx, e.gidx);
        if (got.mv != e.mv) report("chosen_move", got.mv, e.mv);
        if (got.term !== e.term) report("leaf_node", got.term, e.term);
        if (got.full !== e.full) report("fully_expanded", got.full, e.full);
        if (got.st != e.st) report("status", got.st, e.st);
      end
    endtask
  endclass

  localparam int STALL_LIMIT = 60000;

  logic              clk = 0;
  logic              rst = 1;
  logic              in_valid = 0;
  logic              in_ready;
  logic [2:0]        command = '0;
  logic [GIDX_W-1:0] child_id = '0;
  logic [7:0]        score = '0;
  logic [31:0]       random_value = '0;
  logic [5:0]        move_id = '0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [GIDX_W-1:0] chosen_child_index;
  logic [5:0]        chosen_move;
  logic              leaf_node;
  logic              fully_expanded;
  logic [1:0]        status;
  logic              cfg_we = 0;
  logic [1:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  node_scoreboard sb = new;
  bit quiet = 0;      // no idling on either side near the end
  bit long_hold = 0;  // receiver backs off for a long stretch
  int idle_cycles = 0;

  always #2 clk = ~clk;

  mcts_uct_child_selector_unit u_top (.*);

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    node_res_t got;
    if (out_valid && out_ready) begin
      got.gidx = chosen_child_index;
      got.mv   = chosen_move;
      got.term = leaf_node;
      got.full = fully_expanded;
      got.st   = status;
      sb.check(got);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results owed", sb.owed_q.size());
      $display("mcts_uct_child_selector_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random back-pressure bursts, one long hold-off on request
  initial begin
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ready <= 1;
        @(negedge clk);
      end
    end
  end

  // drive one request; called at a falling edge, returns at a falling edge
  task send(node_req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid     <= 1;
    command      <= r.cmd;
    child_id     <= r.cidx;
    score        <= r.scr;
    random_value <= r.rnd;
    move_id      <= r.mv;
    do @(posedge clk); while (!in_ready);
    sb.note(r);
    @(negedge clk);
  endtask

  task send_cmd(logic [2:0] c, logic [23:0] ci, logic [7:0] s, logic [31:0] rv,
                logic [5:0] m);
    node_req_t r;
    r.cmd = c;
    r.cidx = ci;
    r.scr = s;
    r.rnd = rv;
    r.mv = m;
    send(r);
  endtask

  // wait for the block to go idle, then write one register
  task cfg_write(logic [1:0] idx, logic [CFG_W-1:0] val);
    in_valid <= 0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 0;
  endtask

  // random request biased toward children that exist
  function node_req_t rand_req(int cc, int sel_w);
    node_req_t r;
    int w;
    w = $urandom_range(0, 99);
    if (w < sel_w) r.cmd = CMD_SELECT;
    else if (w < 55) r.cmd = CMD_UPDATE;
    else if (w < 66) r.cmd = CMD_EXPAND;
    else if (w < 78) r.cmd = CMD_BEST;
    else if (w < 95) r.cmd = CMD_FIND;
    else r.cmd = 3'($urandom_range(5, 7));
    w = $urandom_range(0, 9);
    if (w < 8) r.cidx = 24'(sb.first_idx + $urandom_range(0, cc));
    else if (w == 8) r.cidx = '0;
    else r.cidx = 24'($urandom);
    r.scr = 8'($urandom_range(0, 255));
    r.rnd = $urandom;
    if ($urandom_range(0, 9) < 7) r.mv = 6'($urandom_range(0, (cc > 0) ? cc - 1 : 0));
    else r.mv = 6'($urandom_range(0, 63));
    return r;
  endfunction

  // one node setting: configure, usually open all the children, then mixed traffic
  task run_node(int cc, logic [23:0] fci, logic [7:0] mes, logic [15:0] ew, int n,
                int sel_w, bit press);
    cfg_write(REG_FIRST_CHILD, CFG_W'(fci));
    cfg_write(REG_MAX_SCORE, CFG_W'(mes));
    cfg_write(REG_EXPLORE, CFG_W'(ew));
    cfg_write(REG_CHILD_COUNT, CFG_W'(cc));
    // leave the node unopened now and then so select misses too
    if ($urandom_range(0, 4) != 0)
      for (int i = 0; i < cc; i++) send_cmd(CMD_EXPAND, '0, '0, $urandom, '0);
    if (press) long_hold = 1;
    for (int i = 0; i < n; i++) send(rand_req(cc, sel_w));
  endtask

  initial begin
    sb.power_up();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // terminal node straight out of reset
    send_cmd(CMD_UPDATE, '0, 8'd255, '0, '0);
    send_cmd(CMD_UPDATE, 24'h000001, 8'd7, '0, '0);
    send_cmd(CMD_SELECT, '0, '0, '1, '0);
    send_cmd(CMD_EXPAND, '0, '0, '1, '0);
    send_cmd(CMD_BEST, '0, '0, '0, '0);
    send_cmd(CMD_FIND, '0, '0, '0, 6'd0);
    send_cmd(3'd7, '1, '1, '1, '1);

    // three children: misses before opening, then the full set of commands
    cfg_write(REG_CHILD_COUNT, CFG_W'(3));
    send_cmd(CMD_SELECT, '0, '0, '0, '0);
    send_cmd(CMD_BEST, '0, '0, '0, '0);
    send_cmd(CMD_FIND, '0, '0, '0, 6'd63);
    send_cmd(CMD_FIND, '0, '0, '0, 6'd2);
    send_cmd(CMD_EXPAND, '0, '0, '1, '0);
    send_cmd(CMD_EXPAND, '0, '0, '0, '0);
    send_cmd(CMD_UPDATE, 24'h000003, 8'd10, '0, '0);  // child 2 not yet open
    send_cmd(CMD_EXPAND, '0, '0, 32'h5555_5555, '0);
    send_cmd(CMD_EXPAND, '0, '0, '0, '0);              // already full
    send_cmd(CMD_SELECT, '0, '0, '1, '0);              // all unvisited, tie pick
    send_cmd(CMD_UPDATE, 24'h000001, 8'd255, '0, '0);
    send_cmd(CMD_UPDATE, 24'h000002, 8'd0, '0, '0);
    send_cmd(CMD_UPDATE, 24'hFFFFFF, 8'd1, '0, '0);    // far out of range
    send_cmd(CMD_UPDATE, 24'h000003, 8'd128, '0, '0);
    send_cmd(CMD_SELECT, '0, '0, 32'hAAAA_AAAA, '0);
    send_cmd(CMD_BEST, '0, '0, '0, '0);
    send_cmd(3'd5, '0, '0, '0, '0);

    // random part over several node settings, extremes first
    run_node(64, 24'hFFFFE0, 8'd255, 16'hFFFF, 20, 4, 0);
    run_node(1, 24'h000000, 8'd1, 16'h0000, 20, 25, 0);
    run_node(2, 24'd12345, 8'd100, 16'd5793, 25, 20, 0);
    run_node(3, 24'($urandom), 8'($urandom_range(1, 255)), 16'($urandom), 25, 20, 1);
    run_node(5, 24'($urandom), 8'($urandom_range(1, 255)), 16'($urandom), 30, 20, 0);
    run_node(8, 24'($urandom), 8'($urandom_range(1, 255)), 16'($urandom), 30, 15, 0);
    quiet = 1;
    run_node(16, 24'($urandom), 8'($urandom_range(1, 255)), 16'($urandom), 35, 10, 0);

    in_valid <= 0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.errors == 0) begin
      $display("mcts_uct_child_selector_unit regression: pass");
    end else begin
      $display("mcts_uct_child_selector_unit regression: fail");
    end
    $finish;
  end

endmodule
